/* sv/lirs_pkg.sv */
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types and constants for the linear interpolation block resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 20;
  localparam int STEP_W   = 17;
  localparam int LEN_W    = 13;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUTS_PER_BLOCK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS_PER_BLOCK = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RATIO_RST        = 17'd67200;
  localparam logic [LEN_W-1:0]  INPUTS_PER_BLOCK_RST  = 13'd2100;
  localparam logic [LEN_W-1:0]  OUTPUTS_PER_BLOCK_RST = 13'd2048;
  localparam logic [STEP_W-1:0] STEP_ONE              = 17'h10000;  // 1.0 in Q1.16

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev_i;
    logic signed [SAMPLE_W-1:0] prev_q;
    logic signed [SAMPLE_W-1:0] cur_i;
    logic signed [SAMPLE_W-1:0] cur_q;
    logic                       block_last;
  } lirs_samp_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_LVL_W-1:0] level;
  } lirs_q_stat_t;

endpackage

/* sv/linear_interp_block_resampler.sv */
// ----------------------------------------------------------------------------
// linear_interp_block_resampler
// Block-wise linear interpolation resampler for signed 16-bit I/Q streams.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one I/Q sample per transaction, I in tdata[15:0], Q in [31:16].
//   out_* : interpolated I/Q, 4 fraction bits, tlast on a block's final output.
//           Inputs that fall between output positions give no transaction.
//   cfg_* : register writes (index 0 step_ratio, 1 inputs_per_block,
//           2 outputs_per_block); always ready, write only while idle.
// Throughput: one sample per cycle while the queue is not full. The front end
//   decides per sample combinationally; the blend pipe takes one output per cycle unless stalled.
// Path: a producing sample is written to the queue when its transaction is
//   accepted, then registered in the multiply stage, then in the round stage
//   into the output reg, from which it is presented on out_*.
// Reset (rst_n low, synchronous): block position, output count and phase
//   return to zero, registers to 67200 / 2100 / 2048, queue and pipe empty.
// Stall: when out_tready is low the output reg holds, the pipe fills, then
//   the four-entry queue; in_tready drops only once the queue is full.
// ----------------------------------------------------------------------------
module linear_interp_block_resampler
  import lirs_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,    // [15:0] sample_i, [31:16] sample_q
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,   // [19:0] out_i, [39:20] out_q
  output logic                 out_tlast,   // block_last
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_data
);

  // position counter holds 0..MAX_BLOCK_LEN
  localparam int POS_W = $clog2(MAX_BLOCK_LEN + 1);
  localparam int Q_W   = $bits(lirs_samp_t) + FRACTION_BITS;

  logic [STEP_W-1:0] step_ratio_r;
  logic [LEN_W-1:0]  inputs_per_block_r;
  logic [LEN_W-1:0]  outputs_per_block_r;

  lirs_q_stat_t               q_stat;
  logic                       f_push;
  lirs_samp_t                 f_samp;
  logic [FRACTION_BITS-1:0]   f_frac;
  logic [POS_W-1:0]           phase_int, position;
  logic [Q_W-1:0]             q_rd_data;
  lirs_samp_t                 b_samp;
  logic [FRACTION_BITS-1:0]   b_frac;
  logic                       b_ready;
  logic signed [OUT_W-1:0]    res_i, res_q;

  // configuration: no back-pressure, decode and write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ratio_r        <= STEP_RATIO_RST;
      inputs_per_block_r  <= INPUTS_PER_BLOCK_RST;
      outputs_per_block_r <= OUTPUTS_PER_BLOCK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_RATIO:        step_ratio_r        <= cfg_data;
        REG_INPUTS_PER_BLOCK:  inputs_per_block_r  <= cfg_data[LEN_W-1:0];
        REG_OUTPUTS_PER_BLOCK: outputs_per_block_r <= cfg_data[LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: position tracking and output decision
  lirs_front #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .FRACTION_BITS (FRACTION_BITS),
    .POS_W         (POS_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .in_sample_i       (in_tdata[15:0]),
    .in_sample_q       (in_tdata[31:16]),
    .step_ratio        (step_ratio_r),
    .inputs_per_block  (inputs_per_block_r),
    .outputs_per_block (outputs_per_block_r),
    .q_full            (q_stat.full),
    .push              (f_push),
    .push_samp         (f_samp),
    .push_frac         (f_frac),
    .phase_int         (phase_int),
    .position          (position)
  );

  // queue of blend jobs
  lirs_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_frac, f_samp}),
    .pop       (b_ready),
    .pop_data  (q_rd_data),
    .stat      (q_stat)
  );

  assign b_samp = q_rd_data[$bits(lirs_samp_t)-1:0];
  assign b_frac = q_rd_data[Q_W-1 -: FRACTION_BITS];

  // back: blend pipe and output register
  lirs_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_stat.empty),
    .in_ready  (b_ready),
    .in_samp   (b_samp),
    .in_frac   (b_frac),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_i     (res_i),
    .out_q     (res_q),
    .out_last  (out_tlast)
  );

  assign out_tdata = {res_q, res_i};

`ifndef ASSERT_OFF
  // queue occupancy never exceeds its depth
  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= Q_LVL_W'(Q_DEPTH))
    else $error("queue level above depth");

  // next output position never runs ahead of the next input index
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_int <= position)
    else $error("phase accumulator ahead of block position");

  // a job is only queued on an accepted input transaction
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> (in_tvalid && in_tready && !q_stat.full))
    else $error("queue push without input transaction");
`endif

endmodule

/* sv/lirs_fifo.sv */
// ----------------------------------------------------------------------------
// lirs_fifo
// Short register queue decoupling the sample front end from the blend pipe.
// ----------------------------------------------------------------------------
module lirs_fifo
  import lirs_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output lirs_q_stat_t     stat
);

  logic [WIDTH-1:0]   mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_LVL_W-1:0] level_r, level_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (level_r == Q_LVL_W'(Q_DEPTH));
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + Q_LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - Q_LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/lirs_front.sv */
// ----------------------------------------------------------------------------
// lirs_front
// Sample front end: block position, phase accumulator, output decision.
// ----------------------------------------------------------------------------
module lirs_front
  import lirs_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = 4096,
  parameter int FRACTION_BITS = 16,
  parameter int POS_W         = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_q,
  input  logic [STEP_W-1:0]          step_ratio,
  input  logic [LEN_W-1:0]           inputs_per_block,
  input  logic [LEN_W-1:0]           outputs_per_block,
  input  logic                       q_full,
  output logic                       push,
  output lirs_samp_t                 push_samp,
  output logic [FRACTION_BITS-1:0]   push_frac,
  output logic [POS_W-1:0]           phase_int,
  output logic [POS_W-1:0]           position
);

  localparam int PH_W = POS_W + FRACTION_BITS;

  logic signed [SAMPLE_W-1:0] prev_i_r, prev_q_r;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt;
  logic [STEP_W-1:0]          step_cl;
  logic [FRACTION_BITS:0]     step_fb;
  logic [POS_W-1:0]           last_pos;
  logic                       accept, emit;

  assign step_cl = (step_ratio < STEP_ONE) ? STEP_ONE : step_ratio;

  // rescale Q1.16 step to the accumulator's fraction width
  generate
    if (FRACTION_BITS >= 16) begin : g_step_up
      assign step_fb = (FRACTION_BITS + 1)'(step_cl) << (FRACTION_BITS - 16);
    end else begin : g_step_down
      assign step_fb = (FRACTION_BITS + 1)'(step_cl >> (16 - FRACTION_BITS));
    end
  endgenerate

  always_comb begin
    if (inputs_per_block < LEN_W'(2)) begin
      last_pos = POS_W'(2);
    end else if (32'(inputs_per_block) > MAX_BLOCK_LEN) begin
      last_pos = POS_W'(MAX_BLOCK_LEN);
    end else begin
      last_pos = POS_W'(inputs_per_block);
    end
  end

  assign phase_int = phase_r[PH_W-1 -: POS_W];
  assign position  = pos_r;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign emit     = (pos_r != '0) && (cnt_r < outputs_per_block) &&
                    (phase_int == pos_r - POS_W'(1));
  assign push     = accept && emit;

  assign push_samp.prev_i     = prev_i_r;
  assign push_samp.prev_q     = prev_q_r;
  assign push_samp.cur_i      = in_sample_i;
  assign push_samp.cur_q      = in_sample_q;
  assign push_samp.block_last = (cnt_r + LEN_W'(1) == outputs_per_block);
  assign push_frac            = phase_r[FRACTION_BITS-1:0];

  always_comb begin
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (emit) begin
        cnt_nxt   = cnt_r + LEN_W'(1);
        phase_nxt = phase_r + PH_W'(step_fb);
      end
      if (pos_r >= last_pos) begin
        // block end: this sample becomes index 0 of the next block
        pos_nxt   = POS_W'(1);
        cnt_nxt   = '0;
        phase_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      cnt_r   <= '0;
      phase_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_i_r <= in_sample_i;
      prev_q_r <= in_sample_q;
    end
  end

endmodule

/* sv/lirs_back.sv */
// ----------------------------------------------------------------------------
// lirs_back
// Blend pipe: difference times fraction, then base add, round and scale.
// ----------------------------------------------------------------------------
module lirs_back
  import lirs_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lirs_samp_t               in_samp,
  input  logic [FRACTION_BITS-1:0] in_frac,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_i,
  output logic signed [OUT_W-1:0]  out_q,
  output logic                     out_last
);

  localparam int PR_W = FRACTION_BITS + 18;

  logic                       s1_v_r, out_v_r;
  logic                       s1_ready, s2_ready;
  logic signed [SAMPLE_W:0]   diff_i, diff_q;
  logic signed [FRACTION_BITS:0] frac_s;
  logic signed [PR_W-1:0]     prod_i, prod_q;
  logic signed [PR_W-1:0]     s1_prod_i_r, s1_prod_q_r;
  logic signed [SAMPLE_W-1:0] s1_prev_i_r, s1_prev_q_r;
  logic                       s1_last_r;
  logic signed [PR_W-1:0]     sum_i, sum_q, rnd;
  logic signed [OUT_W-1:0]    out_i_r, out_q_r;
  logic                       out_last_r;

  assign s2_ready = !out_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // prev*(F-f) + cur*f = prev*F + (cur-prev)*f
  assign diff_i = (SAMPLE_W + 1)'(in_samp.cur_i) - (SAMPLE_W + 1)'(in_samp.prev_i);
  assign diff_q = (SAMPLE_W + 1)'(in_samp.cur_q) - (SAMPLE_W + 1)'(in_samp.prev_q);
  assign frac_s = signed'({1'b0, in_frac});
  assign prod_i = diff_i * frac_s;
  assign prod_q = diff_q * frac_s;

  // times 16, half up: add 2^(FB-5), keep bits from FB-4
  assign rnd   = PR_W'(1) <<< (FRACTION_BITS - 5);
  assign sum_i = (PR_W'(s1_prev_i_r) <<< FRACTION_BITS) + s1_prod_i_r + rnd;
  assign sum_q = (PR_W'(s1_prev_q_r) <<< FRACTION_BITS) + s1_prod_q_r + rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_prod_i_r <= prod_i;
      s1_prod_q_r <= prod_q;
      s1_prev_i_r <= in_samp.prev_i;
      s1_prev_q_r <= in_samp.prev_q;
      s1_last_r   <= in_samp.block_last;
    end
    if (s2_ready && s1_v_r) begin
      out_i_r    <= sum_i[FRACTION_BITS-4 +: OUT_W];
      out_q_r    <= sum_q[FRACTION_BITS-4 +: OUT_W];
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;
  assign out_last  = out_last_r;

endmodule
